### rtl/core/omci_pkg.sv
// package: widths, register indexes, reset values and helpers for the octree cell index
`timescale 1ns / 1ps

package omci_pkg;

   localparam int MAX_LEVELS = 8;
   localparam int LVL_W      = 4;
   localparam int COORD_W    = 32;
   localparam int SIZE_W     = 31;
   localparam int INV_W      = 32;
   localparam int DIST_W     = 31;
   localparam int PROD_W     = DIST_W + INV_W;
   localparam int Q_SHIFT    = 40;
   localparam int Q_W        = PROD_W - Q_SHIFT;
   localparam int CELL_W     = MAX_LEVELS;
   localparam int CODE_W     = 3 * MAX_LEVELS;
   localparam int INDEX_W    = 25;
   localparam int EDGE_W     = 34;
   localparam int SHAMT_W    = $clog2(CODE_W + 1);
   localparam int LANES      = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIVISION_LEVEL = 3'd0,
      CSR_SPACE_SIZE     = 3'd1,
      CSR_CENTER_X       = 3'd2,
      CSR_CENTER_Y       = 3'd3,
      CSR_CENTER_Z       = 3'd4,
      CSR_INV_CELL_SIZE  = 3'd5
   } csr_index_type;

   localparam logic [LVL_W-1:0]  RST_DIVISION_LEVEL = LVL_W'(4);
   localparam logic [SIZE_W-1:0] RST_SPACE_SIZE     = SIZE_W'(65536000);
   localparam logic [INV_W-1:0]  RST_INV_CELL_SIZE  = INV_W'(268435);

   localparam logic KIND_POINT = 1'b0;
   localparam logic KIND_BOX   = 1'b1;

   typedef logic [CELL_W-1:0]  cell_type;
   typedef logic [CODE_W-1:0]  code_type;
   typedef logic [INDEX_W-1:0] index_type;
   typedef logic [LVL_W-1:0]   level_type;

   typedef struct packed {
      logic      valid;
      logic      ok;
      code_type  code;
      level_type groups;
   } s3_type;

   function automatic code_type spread3(input cell_type v);
      code_type r;
      r = '0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
         r[3*i] = v[i];
      end
      return r;
   endfunction

   function automatic index_type level_offset(input level_type lev);
      logic [63:0] s;
      s = '0;
      for (int i = 0; i <= MAX_LEVELS; i++) begin
         if (i < int'(lev)) begin
            s = s + (64'd1 << (3 * i));
         end
      end
      return s[INDEX_W-1:0];
   endfunction

endpackage

### rtl/core/octree_morton_cell_index.sv
// top level: linear octree morton cell index for points and boxes
//
//   channel   signals                          role
//   req       req_valid/req_ready + fields     query transaction in
//   rsp       rsp_valid/rsp_ready + fields     cell transaction out
//   csr       csr_we, csr_index, csr_wdata     register write, no wait
//
// four register stages (edge check, multiply, morton and level search, offset add);
// one transaction per cycle while the output is not stalled; stage two holds the 31x32 multiplier
// synchronous reset clears stage valid bits and restores register defaults
// a stalled output freezes every stage together, so nothing is dropped or repeated
`timescale 1ns / 1ps

module octree_morton_cell_index
   import omci_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_kind,
   input  logic signed [COORD_W-1:0] req_lo_x,
   input  logic signed [COORD_W-1:0] req_lo_y,
   input  logic signed [COORD_W-1:0] req_lo_z,
   input  logic signed [COORD_W-1:0] req_hi_x,
   input  logic signed [COORD_W-1:0] req_hi_y,
   input  logic signed [COORD_W-1:0] req_hi_z,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [INDEX_W-1:0]        rsp_cell_index,
   output logic [LVL_W-1:0]          rsp_cell_level,
   output logic                      rsp_valid_res,
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   // configuration registers
   logic [LVL_W-1:0]          level_ff;
   logic [SIZE_W-1:0]         size_ff;
   logic signed [COORD_W-1:0] center_ff [3];
   logic [INV_W-1:0]          inv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= RST_DIVISION_LEVEL;
         size_ff      <= RST_SPACE_SIZE;
         center_ff[0] <= '0;
         center_ff[1] <= '0;
         center_ff[2] <= '0;
         inv_ff       <= RST_INV_CELL_SIZE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DIVISION_LEVEL: level_ff     <= csr_wdata[LVL_W-1:0];
            CSR_SPACE_SIZE:     size_ff      <= csr_wdata[SIZE_W-1:0];
            CSR_CENTER_X:       center_ff[0] <= csr_wdata[COORD_W-1:0];
            CSR_CENTER_Y:       center_ff[1] <= csr_wdata[COORD_W-1:0];
            CSR_CENTER_Z:       center_ff[2] <= csr_wdata[COORD_W-1:0];
            CSR_INV_CELL_SIZE:  inv_ff       <= csr_wdata[INV_W-1:0];
            default: ;
         endcase
      end
   end

   level_type lev;
   always_comb begin
      if (level_ff == '0) begin
         lev = LVL_W'(1);
      end else if (level_ff > LVL_W'(MAX_LEVELS)) begin
         lev = LVL_W'(MAX_LEVELS);
      end else begin
         lev = level_ff;
      end
   end

   // cube edges per axis
   logic signed [EDGE_W-1:0] lo_edge [3];
   logic signed [EDGE_W-1:0] hi_edge [3];
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         lo_edge[a] = EDGE_W'(center_ff[a])
                      - $signed({{(EDGE_W-SIZE_W+1){1'b0}}, size_ff[SIZE_W-1:1]});
         hi_edge[a] = lo_edge[a] + $signed({{(EDGE_W-SIZE_W){1'b0}}, size_ff});
      end
   end

   logic en;
   logic s1_valid_ff, s2_valid_ff, s4_valid_ff;
   assign en        = !s4_valid_ff || rsp_ready;
   assign req_ready = en;

   // stage 1: inside check and distance from low edge
   logic signed [COORD_W-1:0] pt [LANES];
   assign pt[0] = req_lo_x;
   assign pt[1] = req_lo_y;
   assign pt[2] = req_lo_z;
   assign pt[3] = req_hi_x;
   assign pt[4] = req_hi_y;
   assign pt[5] = req_hi_z;

   logic [DIST_W-1:0]  s1_d_in  [LANES];
   logic [DIST_W-1:0]  s1_d_ff  [LANES];
   logic [LANES-1:0]   s1_in_in, s1_in_ff;
   logic               s1_kind_ff;

   always_comb begin
      logic signed [EDGE_W-1:0] p;
      logic signed [EDGE_W-1:0] diff;
      for (int i = 0; i < LANES; i++) begin
         p           = EDGE_W'(pt[i]);
         diff        = p - lo_edge[i % 3];
         s1_in_in[i] = (p >= lo_edge[i % 3]) && (p <= hi_edge[i % 3]);
         s1_d_in[i]  = diff[DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_d_ff    <= s1_d_in;
         s1_in_ff   <= s1_in_in;
         s1_kind_ff <= req_kind;
      end
   end

   // stage 2: scale to cell coordinates
   logic [PROD_W-1:0] prod [LANES];
   logic [Q_W-1:0]    s2_q_ff [LANES];
   logic [LANES-1:0]  s2_in_ff;
   logic              s2_kind_ff;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         prod[i] = PROD_W'(s1_d_ff[i]) * PROD_W'(inv_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < LANES; i++) begin
            s2_q_ff[i] <= prod[i][PROD_W-1:Q_SHIFT];
         end
         s2_in_ff   <= s1_in_ff;
         s2_kind_ff <= s1_kind_ff;
      end
   end

   // stage 3: clamp, interleave, shared level search
   s3_type s3_in, s3_ff;

   always_comb begin
      logic [Q_W-1:0] top;
      cell_type       cell_q [LANES];
      code_type       code_a, code_b, diff;
      level_type      groups;
      top = Q_W'((64'd1 << lev) - 64'd1);
      for (int i = 0; i < LANES; i++) begin
         cell_q[i] = (s2_q_ff[i] > top) ? top[CELL_W-1:0] : s2_q_ff[i][CELL_W-1:0];
      end
      code_a = spread3(cell_q[0]) | (spread3(cell_q[1]) << 1) | (spread3(cell_q[2]) << 2);
      code_b = spread3(cell_q[3]) | (spread3(cell_q[4]) << 1) | (spread3(cell_q[5]) << 2);
      diff   = code_a ^ code_b;
      groups = '0;
      for (int g = 0; g < MAX_LEVELS; g++) begin
         if (diff[3*g +: 3] != 3'b000) begin
            groups = LVL_W'(g + 1);
         end
      end
      s3_in.valid = s2_valid_ff;
      if (s2_kind_ff == KIND_BOX) begin
         s3_in.ok     = &s2_in_ff;
         s3_in.code   = code_b;
         s3_in.groups = groups;
      end else begin
         s3_in.ok     = &s2_in_ff[2:0];
         s3_in.code   = code_a;
         s3_in.groups = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.valid <= 1'b0;
      end else if (en) begin
         s3_ff.valid <= s3_in.valid;
      end
      if (en) begin
         s3_ff.ok     <= s3_in.ok;
         s3_ff.code   <= s3_in.code;
         s3_ff.groups <= s3_in.groups;
      end
   end

   // stage 4: shift to shared level and add offset
   index_type      s4_index_in, s4_index_ff;
   level_type      s4_level_in, s4_level_ff;
   logic           s4_ok_ff;

   always_comb begin
      logic [SHAMT_W-1:0] shamt;
      code_type           shifted;
      shamt   = SHAMT_W'(s3_ff.groups) * SHAMT_W'(3);
      shifted = s3_ff.code >> shamt;
      if (s3_ff.ok) begin
         s4_level_in = lev - s3_ff.groups;
         s4_index_in = INDEX_W'(shifted) + level_offset(s4_level_in);
      end else begin
         s4_level_in = '0;
         s4_index_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= s3_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_index_ff <= s4_index_in;
         s4_level_ff <= s4_level_in;
         s4_ok_ff    <= s3_ff.ok;
      end
   end

   assign rsp_valid      = s4_valid_ff;
   assign rsp_cell_index = s4_index_ff;
   assign rsp_cell_level = s4_level_ff;
   assign rsp_valid_res  = s4_ok_ff;

`ifndef SYNTH
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |-> (rsp_cell_index == '0 && rsp_cell_level == '0))
      else $error("invalid result carries nonzero index or level");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_valid_res) |-> (rsp_cell_level <= lev))
      else $error("cell level deeper than configured levels");

   a_index_in_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_valid_res) |->
         (rsp_cell_index >= level_offset(rsp_cell_level) &&
          rsp_cell_index <  level_offset(rsp_cell_level + LVL_W'(1))))
      else $error("cell index outside its level range");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid_ff)
      else $error("accepted transaction did not enter the pipeline");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!en && s3_ff.valid) |=> s3_ff.valid)
      else $error("stage three transaction lost during stall");
`endif

endmodule
